>>> rtl/lag_pkg.sv
// Shared types, register codes and fixed-point helpers for the luminance adaptation gain block.
// No dependencies; used by lag_anchor_log and luminance_adaptation_gain.
package lag_pkg;

	localparam int LUM_W    = 48;
	localparam int LOG_FRAC = 20;
	localparam int EXP_W    = 6;
	localparam int LOG_W    = EXP_W + LOG_FRAC;
	localparam int MANT_W   = 32;
	localparam int GAIN_W   = 32;
	localparam int TGAIN_W  = 26;
	localparam int CFG_W    = 48;
	localparam int IDX_W    = 3;

	localparam logic [LUM_W-1:0]   RST_FLOOR_LUM  = 48'd1;
	localparam logic [LUM_W-1:0]   RST_TWI_LUM    = 48'd16777216;
	localparam logic [LUM_W-1:0]   RST_DAY_LUM    = 48'd16777216000;
	localparam logic [GAIN_W-1:0]  RST_FLOOR_GAIN = 32'd524288;
	localparam logic [TGAIN_W-1:0] RST_TWI_GAIN   = 26'd524288;
	localparam logic [TGAIN_W-1:0] RST_DAY_GAIN   = 26'd524288;

	typedef enum logic [IDX_W-1:0] {
		REG_FLOOR_LUM  = 3'd0,
		REG_TWI_LUM    = 3'd1,
		REG_DAY_LUM    = 3'd2,
		REG_FLOOR_GAIN = 3'd3,
		REG_TWI_GAIN   = 3'd4,
		REG_DAY_GAIN   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {RK_DIV, RK_ZERO, RK_ONE} ramp_kind_t;

	typedef enum logic [1:0] {ANC_IDLE, ANC_NORM, ANC_SQR} anc_state_t;

	typedef struct packed {
		logic             busy;
		logic [LOG_W-1:0] log_f;
		logic [LOG_W-1:0] log_t;
		logic [LOG_W-1:0] log_d;
	} anc_log_t;

	typedef struct packed {
		logic [MANT_W-1:0] m;
		logic              b;
	} sq_step_t;

	typedef struct packed {
		logic              byp;
		logic [GAIN_W-1:0] gain;
	} byp_t;

	typedef struct packed {
		ramp_kind_t        kind;
		logic [GAIN_W-1:0] ga;
		logic [GAIN_W-1:0] gb;
		byp_t              bp;
	} ramp_carry_t;

	// Clamp floor: a zero floor register counts as one LSB
	function automatic logic [LUM_W-1:0] lum_floor(input logic [LUM_W-1:0] v);
		return (v == '0) ? LUM_W'(1) : v;
	endfunction

	function automatic logic [LUM_W-1:0] clamp_lo(input logic [LUM_W-1:0] v,
			input logic [LUM_W-1:0] lo);
		return (v > lo) ? v : lo;
	endfunction

	// Index of the highest set bit
	function automatic logic [EXP_W-1:0] lead_one(input logic [LUM_W-1:0] v);
		logic [EXP_W-1:0] e;
		e = '0;
		for (int i = 0; i < LUM_W; i++) begin
			if (v[i]) e = EXP_W'(i);
		end
		return e;
	endfunction

	// Place the leading one at the top of a Q1.31 mantissa, truncating low bits
	function automatic logic [MANT_W-1:0] normalize(input logic [LUM_W-1:0] v,
			input logic [EXP_W-1:0] e);
		logic [LUM_W+MANT_W-1:0] w;
		w = {v, {MANT_W{1'b0}}} >> ({1'b0, e} + 7'd1);
		return w[MANT_W-1:0];
	endfunction

	// One log2 fraction bit: square the mantissa and renormalize
	function automatic sq_step_t sq_step(input logic [MANT_W-1:0] m);
		logic [2*MANT_W-1:0] sq;
		sq_step_t r;
		sq = m * m;
		r.b = sq[2*MANT_W-1];
		r.m = r.b ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];
		return r;
	endfunction

endpackage

>>> rtl/luminance_adaptation_gain.sv
// Top level of the luminance adaptation gain pipeline and its configuration registers.
// Depends on lag_pkg and lag_anchor_log.
//
// Takes one luminance per cycle while in_ready is high and returns one gain per luminance, in
// order. The stages are one each for the floor clamp, the leading-one search and the normalize
// shift, twenty squaring stages for the log2 fraction, section select, ramp classification, one
// restoring-divide stage per ramp fraction bit, two smoothstep multiply stages, one blend
// multiply stage and the output register. The whole pipeline holds while the output is stalled.
// The anchor logs come from a shared squaring unit that runs after reset and after every write
// to one of the three luminance registers; in_ready stays low while it runs. Configuration
// writes are taken at any time.
module luminance_adaptation_gain
	import lag_pkg::*;
#(
	parameter int RAMP_FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [LUM_W:0]    luminance,
	input  logic signed [15:0]       sun_elevation_sin,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic        [GAIN_W-1:0] adaptation_gain,
	input  logic                     cfg_we,
	input  logic        [IDX_W-1:0]  cfg_index,
	input  logic        [CFG_W-1:0]  cfg_data
);

	localparam int R      = RAMP_FRAC_BITS;
	localparam int DV_W   = LOG_W + 2;
	localparam int PROD_W = GAIN_W + R + 1;
	localparam int SUM_W  = GAIN_W + R + 2;
	localparam logic [R:0]       RAMP_ONE  = {1'b1, {R{1'b0}}};
	localparam logic [R+1:0]     THREE_ONE = {2'b11, {R{1'b0}}};
	localparam logic [SUM_W-1:0] HALF      = {{(SUM_W-R){1'b0}}, 1'b1, {(R-1){1'b0}}};

	// Configuration registers
	logic [LUM_W-1:0]   floor_lum_q, twi_lum_q, day_lum_q;
	logic [GAIN_W-1:0]  floor_gain_q;
	logic [TGAIN_W-1:0] twi_gain_q, day_gain_q;

	anc_log_t anc;
	logic restart, adv, take;

	// Front stages
	logic             v_s1, v_s2;
	byp_t             bp_s1, bp_s2;
	logic [LUM_W-1:0] l_s1, l_s2;
	logic [EXP_W-1:0] e_s2;

	// Log stages; element 0 is the normalized mantissa
	logic              lg_v_s [0:LOG_FRAC];
	logic [MANT_W-1:0] lg_m_s [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] lg_f_s [0:LOG_FRAC];
	logic [EXP_W-1:0]  lg_e_s [0:LOG_FRAC];
	byp_t              lg_b_s [0:LOG_FRAC];

	// Select and classify
	logic                v_s5;
	logic signed [LOG_W:0] num_s5, den_s5;
	ramp_carry_t         rc_s5;
	logic [LOG_W-1:0]    log_l, x0, x1;
	ramp_kind_t          kind;
	logic [LOG_W:0]      un, ud;

	// Divide stages; element 0 holds the classified operands
	logic              dv_v_s  [0:R];
	logic [DV_W-1:0]   dv_r_s  [0:R];
	logic [LOG_W:0]    dv_ud_s [0:R];
	logic [R-1:0]      dv_q_s  [0:R];
	ramp_carry_t       dv_c_s  [0:R];

	// Smoothstep and blend
	logic              v_s7, v_s8, v_s9;
	ramp_carry_t       rc_s7, rc_s8, rc_s9;
	logic [R-1:0]      t2_s7;
	logic [R+1:0]      w_s7;
	logic [2*R-1:0]    tt;
	logic [2*R+1:0]    pw;
	logic [R:0]        s_nx, s_s8;
	logic [PROD_W-1:0] pa_s9, pb_s9;
	logic [SUM_W-1:0]  sum;

	logic              out_valid_q;
	logic [GAIN_W-1:0] gain_q;

	assign restart = cfg_we && (cfg_index == REG_FLOOR_LUM || cfg_index == REG_TWI_LUM ||
		cfg_index == REG_DAY_LUM);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_lum_q  <= RST_FLOOR_LUM;
			twi_lum_q    <= RST_TWI_LUM;
			day_lum_q    <= RST_DAY_LUM;
			floor_gain_q <= RST_FLOOR_GAIN;
			twi_gain_q   <= RST_TWI_GAIN;
			day_gain_q   <= RST_DAY_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLOOR_LUM:  floor_lum_q  <= cfg_data[LUM_W-1:0];
				REG_TWI_LUM:    twi_lum_q    <= cfg_data[LUM_W-1:0];
				REG_DAY_LUM:    day_lum_q    <= cfg_data[LUM_W-1:0];
				REG_FLOOR_GAIN: floor_gain_q <= cfg_data[GAIN_W-1:0];
				REG_TWI_GAIN:   twi_gain_q   <= cfg_data[TGAIN_W-1:0];
				REG_DAY_GAIN:   day_gain_q   <= cfg_data[TGAIN_W-1:0];
				default: ;
			endcase
		end
	end

	lag_anchor_log u_anchor (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.floor_lum (floor_lum_q),
		.twi_lum   (twi_lum_q),
		.day_lum   (day_lum_q),
		.anc       (anc)
	);

	// Hold every stage while the output register is stalled
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && !anc.busy;
	assign take     = in_valid && in_ready;

	// Valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			lg_v_s[0]   <= 1'b0;
			v_s5        <= 1'b0;
			dv_v_s[0]   <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= take;
			v_s2        <= v_s1;
			lg_v_s[0]   <= v_s2;
			v_s5        <= lg_v_s[LOG_FRAC];
			dv_v_s[0]   <= v_s5;
			v_s7        <= dv_v_s[R];
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			out_valid_q <= v_s9;
		end
	end

	// Clamp the luminance, find its leading one, normalize
	always_ff @(posedge clk) begin
		if (adv) begin
			bp_s1.byp  <= luminance[LUM_W];
			bp_s1.gain <= (sun_elevation_sin > 16'sd0) ?
				{{(GAIN_W-TGAIN_W){1'b0}}, day_gain_q} : floor_gain_q;
			l_s1       <= clamp_lo(luminance[LUM_W-1:0], lum_floor(floor_lum_q));
			bp_s2      <= bp_s1;
			l_s2       <= l_s1;
			e_s2       <= lead_one(l_s1);
			lg_m_s[0]  <= normalize(l_s2, e_s2);
			lg_e_s[0]  <= e_s2;
			lg_f_s[0]  <= '0;
			lg_b_s[0]  <= bp_s2;
		end
	end

	// Log2 fraction, one bit per stage
	for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
		sq_step_t st;
		assign st = sq_step(lg_m_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lg_v_s[k+1] <= 1'b0;
			else if (adv) lg_v_s[k+1] <= lg_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lg_m_s[k+1] <= st.m;
				lg_f_s[k+1] <= {lg_f_s[k][LOG_FRAC-2:0], st.b};
				lg_e_s[k+1] <= lg_e_s[k];
				lg_b_s[k+1] <= lg_b_s[k];
			end
		end
	end

	// Pick the ramp section
	always_comb begin
		log_l = {lg_e_s[LOG_FRAC], lg_f_s[LOG_FRAC]};
		if (log_l > anc.log_t) begin
			x0 = anc.log_t;
			x1 = anc.log_d;
		end else begin
			x0 = anc.log_f;
			x1 = anc.log_t;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5   <= $signed({1'b0, log_l}) - $signed({1'b0, x0});
			den_s5   <= $signed({1'b0, x1}) - $signed({1'b0, x0});
			rc_s5.bp <= lg_b_s[LOG_FRAC];
			rc_s5.kind <= RK_DIV;
			if (log_l > anc.log_t) begin
				rc_s5.ga <= {{(GAIN_W-TGAIN_W){1'b0}}, twi_gain_q};
				rc_s5.gb <= {{(GAIN_W-TGAIN_W){1'b0}}, day_gain_q};
			end else begin
				rc_s5.ga <= floor_gain_q;
				rc_s5.gb <= {{(GAIN_W-TGAIN_W){1'b0}}, twi_gain_q};
			end
		end
	end

	// Classify the ramp: step, saturated ends, or a true division
	always_comb begin
		kind = RK_DIV;
		un   = '0;
		ud   = '0;
		if (den_s5 == 0) begin
			kind = (num_s5 >= 0) ? RK_ONE : RK_ZERO;
		end else if (!den_s5[LOG_W]) begin
			if (num_s5 <= 0) kind = RK_ZERO;
			else if (num_s5 >= den_s5) kind = RK_ONE;
			else begin
				un = num_s5;
				ud = den_s5;
			end
		end else begin
			if (num_s5 >= 0) kind = RK_ZERO;
			else if (num_s5 <= den_s5) kind = RK_ONE;
			else begin
				un = -num_s5;
				ud = -den_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_r_s[0]  <= {1'b0, un};
			dv_ud_s[0] <= ud;
			dv_q_s[0]  <= '0;
			dv_c_s[0]  <= '{kind: kind, ga: rc_s5.ga, gb: rc_s5.gb, bp: rc_s5.bp};
		end
	end

	// Restoring divide, one quotient bit per stage
	for (genvar k = 0; k < R; k++) begin : g_div
		logic [DV_W-1:0] r2;
		logic            ge;
		assign r2 = {dv_r_s[k][DV_W-2:0], 1'b0};
		assign ge = (r2 >= {1'b0, dv_ud_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k+1] <= 1'b0;
			else if (adv) dv_v_s[k+1] <= dv_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_r_s[k+1]  <= ge ? (r2 - {1'b0, dv_ud_s[k]}) : r2;
				dv_q_s[k+1]  <= {dv_q_s[k][R-2:0], ge};
				dv_ud_s[k+1] <= dv_ud_s[k];
				dv_c_s[k+1]  <= dv_c_s[k];
			end
		end
	end

	// Smoothstep: square, then weight by three minus twice t
	assign tt = dv_q_s[R] * dv_q_s[R];
	assign pw = t2_s7 * w_s7;

	always_comb begin
		case (rc_s7.kind)
			RK_ZERO: s_nx = '0;
			RK_ONE:  s_nx = RAMP_ONE;
			default: s_nx = pw[2*R:R];
		endcase
	end

	// Blend the two gains and round half up
	assign sum = {1'b0, pa_s9} + {1'b0, pb_s9} + HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			t2_s7  <= tt[2*R-1:R];
			w_s7   <= THREE_ONE - {1'b0, dv_q_s[R], 1'b0};
			rc_s7  <= dv_c_s[R];
			s_s8   <= s_nx;
			rc_s8  <= rc_s7;
			pa_s9  <= rc_s8.ga * (RAMP_ONE - s_s8);
			pb_s9  <= rc_s8.gb * s_s8;
			rc_s9  <= rc_s8;
			gain_q <= rc_s9.bp.byp ? rc_s9.bp.gain : sum[R+GAIN_W-1:R];
		end
	end

	assign out_valid       = out_valid_q;
	assign adaptation_gain = gain_q;

	// The ramp weight never passes one
	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (s_s8 <= RAMP_ONE))
		else $error("ramp weight above one");

	// A division is only started with a proper fraction
	a_div_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && kind == RK_DIV) |-> (un < ud))
		else $error("divide operands out of order");

	// An anchor write closes the input until the logs are rebuilt
	a_restart_block: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> !in_ready)
		else $error("input open during anchor update");

endmodule

>>> rtl/lag_anchor_log.sv
// Sequential log2 of the three clamped anchor luminances, one squaring per cycle.
// Depends on lag_pkg; instantiated by luminance_adaptation_gain.
module lag_anchor_log
	import lag_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [LUM_W-1:0] floor_lum,
	input  logic [LUM_W-1:0] twi_lum,
	input  logic [LUM_W-1:0] day_lum,
	output anc_log_t         anc
);

	localparam int CNT_W = $clog2(LOG_FRAC);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LOG_FRAC - 1);
	localparam logic [1:0] IDX_LAST = 2'd2;

	anc_state_t state_q, state_nx;
	logic [1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MANT_W-1:0] m_q;
	logic [EXP_W-1:0] e_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [LOG_W-1:0] log_f_q, log_t_q, log_d_q;
	logic [LUM_W-1:0] lo, v_sel;
	logic [EXP_W-1:0] e_sel;
	sq_step_t step;
	logic do_norm, do_sqr, last_sqr;

	// Select the clamped anchor under work
	always_comb begin
		lo = lum_floor(floor_lum);
		case (idx_q)
			2'd0:    v_sel = lo;
			2'd1:    v_sel = clamp_lo(twi_lum, lo);
			default: v_sel = clamp_lo(day_lum, lo);
		endcase
	end

	assign e_sel    = lead_one(v_sel);
	assign step     = sq_step(m_q);
	assign last_sqr = (cnt_q == CNT_LAST);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ANC_IDLE: state_nx = ANC_IDLE;
			ANC_NORM: state_nx = ANC_SQR;
			ANC_SQR: begin
				if (last_sqr) state_nx = (idx_q == IDX_LAST) ? ANC_IDLE : ANC_NORM;
			end
			default: state_nx = ANC_IDLE;
		endcase
		if (restart) state_nx = ANC_NORM;
	end

	// State outputs
	always_comb begin
		do_norm  = (state_q == ANC_NORM);
		do_sqr   = (state_q == ANC_SQR);
	end

	assign anc.busy  = (state_q != ANC_IDLE);
	assign anc.log_f = log_f_q;
	assign anc.log_t = log_t_q;
	assign anc.log_d = log_d_q;

	// Advance control: start over after reset and after an anchor write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ANC_NORM;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (restart) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (do_norm) begin
				cnt_q <= '0;
			end else if (do_sqr) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_sqr) idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Normalize, square, and store each finished log
	always_ff @(posedge clk) begin
		if (do_norm) begin
			e_q    <= e_sel;
			m_q    <= normalize(v_sel, e_sel);
			frac_q <= '0;
		end else if (do_sqr) begin
			m_q    <= step.m;
			frac_q <= {frac_q[LOG_FRAC-2:0], step.b};
			if (last_sqr) begin
				case (idx_q)
					2'd0:    log_f_q <= {e_q, frac_q[LOG_FRAC-2:0], step.b};
					2'd1:    log_t_q <= {e_q, frac_q[LOG_FRAC-2:0], step.b};
					default: log_d_q <= {e_q, frac_q[LOG_FRAC-2:0], step.b};
				endcase
			end
		end
	end

endmodule

>>> test/tb_top.sv
// Testbench for luminance_adaptation_gain: directed and random luminance traffic across
// several register settings, checked against a bit-exact gain predictor. Depends on lag_pkg.
`timescale 1ns / 100ps

module tb_top
	import lag_pkg::*;
();

	localparam int RAMP_BITS = 16;
	localparam int LOG_BITS  = 20;
	localparam int LATENCY   = 29 + RAMP_BITS;
	localparam int ANCHOR_CYCLES = 63;
	localparam longint unsigned CYCLE_LIMIT = 400000;
	localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [CFG_W-1:0] ALL_ONES = '1;

	// Gain predictor with its own copy of the registers and a queue of expected gains
	class gain_scoreboard;
		logic [LUM_W-1:0] floor_lum, twi_lum, day_lum;
		logic [GAIN_W-1:0] floor_gain;
		logic [TGAIN_W-1:0] twi_gain, day_gain;
		logic [GAIN_W-1:0] expected_gains[$];
		int errors;

		function new();
			floor_lum = RST_FLOOR_LUM;
			twi_lum = RST_TWI_LUM;
			day_lum = RST_DAY_LUM;
			floor_gain = RST_FLOOR_GAIN;
			twi_gain = RST_TWI_GAIN;
			day_gain = RST_DAY_GAIN;
			errors = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FLOOR_LUM: floor_lum = data;
				REG_TWI_LUM: twi_lum = data;
				REG_DAY_LUM: day_lum = data;
				REG_FLOOR_GAIN: floor_gain = data[GAIN_W-1:0];
				REG_TWI_GAIN: twi_gain = data[TGAIN_W-1:0];
				REG_DAY_GAIN: day_gain = data[TGAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Fixed-point log2 by repeated squaring of the normalized mantissa
		function longint log2_fx(longint unsigned v);
			longint unsigned m, sq, frac;
			int e;
			e = 0;
			frac = 0;
			if (v == 0) v = 1;
			for (int i = 63; i >= 0; i--) begin
				if (v[i]) begin
					e = i;
					break;
				end
			end
			m = (e <= 31) ? (v << (31 - e)) : (v >> (e - 31));
			for (int i = 0; i < LOG_BITS; i++) begin
				sq = m * m;
				frac = frac << 1;
				if (sq[63]) begin
					frac = frac | 1;
					m = sq >> 32;
				end else begin
					m = sq >> 31;
				end
			end
			return longint'((64'(e) << LOG_BITS) | frac);
		endfunction

		// Smoothstep of the position of x between x0 and x1
		function longint unsigned ease(longint x, longint x0, longint x1);
			longint unsigned one, un, ud, t, t2;
			longint num, den;
			one = 64'd1 << RAMP_BITS;
			num = x - x0;
			den = x1 - x0;
			if (den == 0) return (x >= x1) ? one : 0;
			if (den > 0) begin
				if (num <= 0) return 0;
				if (num >= den) return one;
				un = num;
				ud = den;
			end else begin
				if (num >= 0) return 0;
				if (num <= den) return one;
				un = -num;
				ud = -den;
			end
			t = (un << RAMP_BITS) / ud;
			t2 = (t * t) >> RAMP_BITS;
			return (t2 * (3 * one - 2 * t)) >> RAMP_BITS;
		endfunction

		function logic [GAIN_W-1:0] mix(longint unsigned a, longint unsigned b,
				longint unsigned s);
			longint unsigned one, sum;
			one = 64'd1 << RAMP_BITS;
			sum = a * (one - s) + b * s + (one >> 1);
			return sum[RAMP_BITS +: GAIN_W];
		endfunction

		function void note_input(logic signed [LUM_W:0] lum, logic signed [15:0] sun);
			longint unsigned lo, l, tw, dy;
			longint log_l, log_f, log_t, log_d;
			logic [GAIN_W-1:0] g;
			if (lum < 0) begin
				g = (sun > 0) ? GAIN_W'(day_gain) : floor_gain;
			end else begin
				lo = (floor_lum == 0) ? 64'd1 : 64'(floor_lum);
				l = (64'(lum[LUM_W-1:0]) > lo) ? 64'(lum[LUM_W-1:0]) : lo;
				tw = (64'(twi_lum) > lo) ? 64'(twi_lum) : lo;
				dy = (64'(day_lum) > lo) ? 64'(day_lum) : lo;
				log_l = log2_fx(l);
				log_f = log2_fx(lo);
				log_t = log2_fx(tw);
				log_d = log2_fx(dy);
				if (log_l <= log_t)
					g = mix(64'(floor_gain), 64'(twi_gain), ease(log_l, log_f, log_t));
				else
					g = mix(64'(twi_gain), 64'(day_gain), ease(log_l, log_t, log_d));
			end
			expected_gains.push_back(g);
		endfunction

		function void check(logic [GAIN_W-1:0] got);
			logic [GAIN_W-1:0] want;
			if (expected_gains.size() == 0) begin
				$display("%0t: unexpected gain %h", $time, got);
				errors++;
				return;
			end
			want = expected_gains.pop_front();
			if (got !== want) begin
				$display("%0t: gain mismatch, expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [LUM_W:0] luminance;
	logic signed [15:0] sun_elevation_sin;
	logic [GAIN_W-1:0] adaptation_gain;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	gain_scoreboard sb;
	bit hold_request;
	longint unsigned cycles;

	luminance_adaptation_gain #(.RAMP_FRAC_BITS(RAMP_BITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.luminance(luminance), .sun_elevation_sin(sun_elevation_sin),
		.out_valid(out_valid), .out_ready(out_ready),
		.adaptation_gain(adaptation_gain),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Check each accepted gain transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check(adaptation_gain);
	end

	// Drive out_ready: stall pattern picked at random for each span, long hold on request
	initial begin
		int mode, span;
		out_ready = 1'b0;
		mode = 0;
		span = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (399) @(negedge clk);
				hold_request = 0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(20, 80);
				end
				span--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one luminance transaction and hold it until accepted
	task automatic send(logic signed [LUM_W:0] lum, logic signed [15:0] sun);
		@(negedge clk);
		in_valid <= 1'b1;
		luminance <= lum;
		sun_elevation_sin <= sun;
		do @(posedge clk); while (!in_ready);
		sb.note_input(lum, sun);
	endtask

	task automatic pause(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Drain all expected gains, then let the anchor unit settle
	task automatic drain();
		pause(0);
		while (sb.expected_gains.size() != 0) @(posedge clk);
		repeat (LATENCY + ANCHOR_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [LUM_W:0] rand_lum();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return r[LUM_W:0] | {1'b1, {LUM_W{1'b0}}};
			1: return r[LUM_W:0];
			2: return {1'b0, sb.twi_lum} + $signed($urandom_range(0, 64)) - 32;
			3: return {1'b0, sb.day_lum} + $signed($urandom_range(0, 64)) - 32;
			4: return {1'b0, sb.floor_lum} + $urandom_range(0, 3);
			default: return {1'b0, r[LUM_W-1:0] >> $urandom_range(0, LUM_W - 1)};
		endcase
	endfunction

	function automatic logic signed [15:0] rand_sun();
		if ($urandom_range(0, 7) == 0) return '0;
		return 16'($urandom);
	endfunction

	task automatic run_random(int n);
		int burst, gap;
		while (n > 0) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && n > 0; i++, n--) send(rand_lum(), rand_sun());
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) pause(gap);
		end
	endtask

	task automatic set_all(logic [CFG_W-1:0] fl, logic [CFG_W-1:0] tl, logic [CFG_W-1:0] dl,
			logic [CFG_W-1:0] fg, logic [CFG_W-1:0] tg, logic [CFG_W-1:0] dg);
		write_reg(REG_FLOOR_LUM, fl);
		write_reg(REG_TWI_LUM, tl);
		write_reg(REG_DAY_LUM, dl);
		write_reg(REG_FLOOR_GAIN, fg);
		write_reg(REG_TWI_GAIN, tg);
		write_reg(REG_DAY_GAIN, dg);
	endtask

	initial begin
		logic signed [LUM_W:0] lum_max, lum_min;
		sb = new();
		cycles = 0;
		hold_request = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		luminance = '0;
		sun_elevation_sin = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FLOOR_LUM;
		cfg_data = '0;
		lum_max = {1'b0, {LUM_W{1'b1}}};
		lum_min = {1'b1, {LUM_W{1'b0}}};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: no measurement with every sun sign, then extremes and anchors
		set_all(48'd1 << 20, 48'd1 << 24, 48'd1000 << 24, 48'd1 << 18, 48'd3 << 19, 48'd5 << 19);
		send(-49'sd1, 16'sd1);
		send(lum_min, 16'sd32767);
		send(-49'sd5, 16'sd0);
		send(-49'sd7, -16'sd1);
		send(lum_min, -16'sd32768);
		send(49'sd0, 16'sd1);
		send(49'sd1, 16'sd0);
		send(49'sd1 << 20, 16'sd0);
		send((49'sd1 << 22) + 3, 16'sd0);
		send((49'sd1 << 24) - 1, 16'sd0);
		send(49'sd1 << 24, 16'sd0);
		send((49'sd1 << 24) + 1, 16'sd0);
		send(49'sd300 << 24, 16'sd0);
		send(49'sd1000 << 24, 16'sd0);
		send(lum_max, -16'sd1);
		send(49'sh0_5555_5555_5555, 16'sh5555);
		send(49'sh0_AAAA_AAAA_AAAA, -16'sh5556);
		drain();

		// Reset luminance anchors and floor gain; long output hold while input keeps coming
		set_all(RST_FLOOR_LUM, RST_TWI_LUM, RST_DAY_LUM,
			48'(RST_FLOOR_GAIN), 48'd1 << 17, 48'd3 << 20);
		hold_request = 1;
		run_random(300);
		drain();

		// Zero floor, widest gains, reversed day below twilight
		set_all(48'd0, 48'd1 << 30, 48'd1 << 10, 48'd2147483648, 48'd33554432, 48'd0);
		run_random(200);
		drain();

		// Equal anchors give steps
		set_all(48'd1 << 16, 48'd1 << 28, 48'd1 << 28, 48'd0, 48'd12345, 48'd33554432);
		run_random(200);
		pause(0);
		while (sb.expected_gains.size() != 0) @(posedge clk);
		run_random(50);
		drain();

		// Anchors at the top of the range and below the floor; gains over range
		set_all(ALL_ONES, 48'd5, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		write_reg(REG_SPARE_6, ALL_ONES);
		write_reg(REG_SPARE_7, '0);
		run_random(200);
		drain();

		// Random settings
		for (int p = 0; p < 4; p++) begin
			set_all(48'({$urandom, $urandom} >> $urandom_range(16, 47)),
				48'({$urandom, $urandom} >> $urandom_range(16, 40)),
				48'({$urandom, $urandom} >> $urandom_range(16, 30)),
				48'($urandom), 48'($urandom), 48'($urandom));
			run_random(110);
			drain();
		end

		if (sb.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
